>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the bvmf_checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BVMF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define BVMF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/bvmf_pkg.sv
// ----------------------------------------------------------------------------
// bvmf_pkg
// Types and constants of the bus voltage monitor filter.
// ----------------------------------------------------------------------------
package bvmf_pkg;

  localparam int TIME_W = 32;
  localparam int RAW_W  = 12;
  localparam int MV_W   = 16;
  localparam int PER_W  = 16;
  localparam int REF_W  = 13;
  localparam int RAT_W  = 4;
  localparam int SHF_W  = 3;

  // Width of raw * reference * ratio plus rounding half.
  localparam int PROD_W = RAW_W + REF_W + RAT_W + 1;

  localparam int ADC_BITS_DEF  = 12;
  localparam int TIME_BITS_DEF = 32;

  localparam int QDEPTH = 2;

  localparam logic [PER_W-1:0] PERIOD_RST = PER_W'(20);
  localparam logic [REF_W-1:0] REF_RST    = REF_W'(3300);
  localparam logic [RAT_W-1:0] RATIO_RST  = RAT_W'(11);
  localparam logic [SHF_W-1:0] SHIFT_RST  = SHF_W'(2);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_REF    = 2'd1,
    REG_RATIO  = 2'd2,
    REG_SHIFT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              read_ok;
    logic [RAW_W-1:0]  raw_sample;
  } poll_t;

  typedef struct packed {
    logic [MV_W-1:0]  bus_millivolts;
    logic [RAW_W-1:0] last_raw;
    logic             reading_valid;
    logic             sample_taken;
  } result_t;

  typedef struct packed {
    logic [PER_W-1:0] sample_period_ms;
    logic [REF_W-1:0] reference_mv;
    logic [RAT_W-1:0] divider_ratio;
    logic [SHF_W-1:0] filter_shift;
  } cfg_t;

  // One classified poll on its way to the back end.
  typedef struct packed {
    logic             take;
    logic [RAW_W-1:0] raw;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic nonempty;
    job_t job;
  } head_t;

endpackage

>>> src/bvmf_front.sv
// ----------------------------------------------------------------------------
// bvmf_front
// Accepts polls, decides whether each one is due and queues the decision.
// ----------------------------------------------------------------------------
module bvmf_front #(
  parameter int TIME_BITS = bvmf_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              poll_valid,
  output logic                              poll_stall,
  input  bvmf_pkg::poll_t                   poll,
  input  logic [bvmf_pkg::PER_W-1:0]        sample_period_ms,
  input  logic                              queue_full,
  output bvmf_pkg::push_t                   push
);

  logic [TIME_BITS-1:0] last_time;
  logic                 first_pending;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 due;
  logic                 accept;

  assign poll_stall = queue_full;
  assign accept     = poll_valid && !queue_full;

  assign now_t   = poll.now_ms[TIME_BITS-1:0];
  assign elapsed = now_t - last_time;
  assign due     = first_pending || (elapsed >= TIME_BITS'(sample_period_ms));

  assign push.valid    = accept;
  assign push.job.take = due && poll.read_ok;
  assign push.job.raw  = poll.raw_sample;

  // A due poll restarts the period even when the read failed.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time     <= '0;
      first_pending <= 1'b1;
    end else if (accept && due) begin
      last_time     <= now_t;
      first_pending <= 1'b0;
    end
  end

endmodule

>>> src/bvmf_queue.sv
// ----------------------------------------------------------------------------
// bvmf_queue
// Short queue of classified polls between the front and back ends.
// ----------------------------------------------------------------------------
module bvmf_queue (
  input  logic            clk,
  input  logic            rst,
  input  bvmf_pkg::push_t push,
  input  logic            pop,
  output logic            full,
  output bvmf_pkg::head_t head
);

  localparam int PW = (bvmf_pkg::QDEPTH > 1) ? $clog2(bvmf_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(bvmf_pkg::QDEPTH + 1);

  bvmf_pkg::job_t entries [bvmf_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full          = (count == CW'(bvmf_pkg::QDEPTH));
  assign head.nonempty = (count != '0);
  assign head.job      = entries[rd_ptr];
  assign do_push       = push.valid && !full;
  assign do_pop        = pop && head.nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(bvmf_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(bvmf_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/bvmf_back.sv
// ----------------------------------------------------------------------------
// bvmf_back
// Scales sampled codes to millivolts, runs the moving average and drives
// the result register.
// ----------------------------------------------------------------------------
module bvmf_back #(
  parameter int ADC_BITS = bvmf_pkg::ADC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bvmf_pkg::cfg_t    cfg,
  input  bvmf_pkg::head_t   head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output bvmf_pkg::result_t result
);

  localparam int RAW_W  = bvmf_pkg::RAW_W;
  localparam int MV_W   = bvmf_pkg::MV_W;
  localparam int PROD_W = bvmf_pkg::PROD_W;
  localparam int P1_W   = bvmf_pkg::RAW_W + bvmf_pkg::REF_W;
  localparam int Q_W    = PROD_W - ADC_BITS + 1;
  localparam int FULL_W = PROD_W + Q_W;
  localparam int EXT_W  = Q_W + MV_W + 1;
  localparam longint unsigned FS = (64'd1 << ADC_BITS) - 64'd1;
  localparam logic [RAW_W-1:0]  RAW_MASK = RAW_W'(FS);
  localparam logic [PROD_W-1:0] HALF     = PROD_W'(FS / 64'd2);
  // floor(2^PROD_W / FS): the estimate is at most one short.
  localparam logic [Q_W-1:0]    RECIP    = Q_W'((64'd1 << PROD_W) / FS);
  localparam logic [EXT_W-1:0]  MV_MAX   = EXT_W'((64'd1 << MV_W) - 64'd1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL1  = 7'b0000010,
    S_MUL2  = 7'b0000100,
    S_RECIP = 7'b0001000,
    S_CORR  = 7'b0010000,
    S_FILT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [RAW_W-1:0]   raw_r;
  logic               take_r;
  logic [P1_W-1:0]    prod1;
  logic [PROD_W-1:0]  num;
  logic [Q_W-1:0]     quo;
  logic [Q_W-1:0]     mv_q;
  logic [MV_W-1:0]    filt;
  logic               loaded;
  logic [RAW_W-1:0]   held_raw;

  logic [FULL_W-1:0]  full_prod;
  logic [PROD_W:0]    q_times_fs;
  logic [PROD_W:0]    rem;
  logic [EXT_W-1:0]   mv_ext;
  logic [MV_W-1:0]    mv_sat;
  logic signed [MV_W:0] diff;
  logic signed [MV_W:0] bias;
  logic signed [MV_W:0] step;
  logic               out_free;

  assign out_free = !result_valid || !result_stall;
  assign pop      = (state == S_IDLE) && head.nonempty;

  assign full_prod  = FULL_W'(num) * FULL_W'(RECIP);
  assign q_times_fs = ((PROD_W + 1)'(quo) << ADC_BITS) - (PROD_W + 1)'(quo);
  assign rem        = {1'b0, num} - q_times_fs;

  assign mv_ext = EXT_W'(mv_q);
  assign mv_sat = (mv_ext > MV_MAX) ? MV_MAX[MV_W-1:0] : mv_ext[MV_W-1:0];

  // Arithmetic shift rounds down; bias negatives to truncate toward zero.
  assign diff = $signed({1'b0, mv_sat}) - $signed({1'b0, filt});
  assign bias = diff[MV_W] ? $signed(((MV_W + 1)'(1) << cfg.filter_shift) - (MV_W + 1)'(1))
                           : '0;
  assign step = (diff + bias) >>> cfg.filter_shift;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head.nonempty) begin
          state_next = head.job.take ? S_MUL1 : S_OUT;
        end
      end
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_RECIP;
      S_RECIP: state_next = S_CORR;
      S_CORR:  state_next = S_FILT;
      S_FILT:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: at most one multiply per step.
  always_ff @(posedge clk) begin
    if (pop) begin
      raw_r  <= head.job.raw & RAW_MASK;
      take_r <= head.job.take;
    end
    if (state == S_MUL1) begin
      prod1 <= P1_W'(raw_r) * P1_W'(cfg.reference_mv);
    end
    if (state == S_MUL2) begin
      num <= PROD_W'(prod1) * PROD_W'(cfg.divider_ratio) + HALF;
    end
    if (state == S_RECIP) begin
      quo <= full_prod[FULL_W-1:PROD_W];
    end
    if (state == S_CORR) begin
      mv_q <= (rem >= (PROD_W + 1)'(FS)) ? quo + 1'b1 : quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt     <= '0;
      loaded   <= 1'b0;
      held_raw <= '0;
    end else if (state == S_FILT) begin
      held_raw <= raw_r;
      loaded   <= 1'b1;
      if (!loaded) begin
        filt <= mv_sat;
      end else begin
        filt <= filt + step[MV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      result.bus_millivolts <= filt;
      result.last_raw       <= held_raw;
      result.reading_valid  <= loaded;
      result.sample_taken   <= take_r;
    end
  end

endmodule

>>> src/bus_voltage_monitor_filter_top.sv
// Path: a poll that is not sampled passes the queue and the back end's idle and output
//   states; a sampled poll also passes two multiplies, reciprocal, fix-up and filter.
// The back end takes a new poll from the queue only after the last one has left its
//   output state, which waits while the result is stalled.
// Reset (synchronous, active high) restores the register defaults, empties the
//   queue and clears the filter; the first poll after it is always due.
// ----------------------------------------------------------------------------
// bus_voltage_monitor_filter_top
// Bus voltage monitor: sample timing, ADC scaling and moving-average filter.
// ----------------------------------------------------------------------------
module bus_voltage_monitor_filter_top #(
  parameter int ADC_BITS  = bvmf_pkg::ADC_BITS_DEF,
  parameter int TIME_BITS = bvmf_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          poll_valid,
  output logic                          poll_stall,
  input  bvmf_pkg::poll_t               poll,
  output logic                          result_valid,
  input  logic                          result_stall,
  output bvmf_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bvmf_pkg::APB_AW-1:0]   paddr,
  input  logic [bvmf_pkg::APB_DW-1:0]   pwdata,
  output logic [bvmf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  bvmf_pkg::cfg_t    cfg;
  bvmf_pkg::push_t   push;
  bvmf_pkg::head_t   head;
  bvmf_pkg::reg_idx_t reg_idx;
  logic              queue_full;
  logic              pop;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = bvmf_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period_ms <= bvmf_pkg::PERIOD_RST;
      cfg.reference_mv     <= bvmf_pkg::REF_RST;
      cfg.divider_ratio    <= bvmf_pkg::RATIO_RST;
      cfg.filter_shift     <= bvmf_pkg::SHIFT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bvmf_pkg::REG_PERIOD: cfg.sample_period_ms <= pwdata[bvmf_pkg::PER_W-1:0];
        bvmf_pkg::REG_REF:    cfg.reference_mv     <= pwdata[bvmf_pkg::REF_W-1:0];
        bvmf_pkg::REG_RATIO:  cfg.divider_ratio    <= pwdata[bvmf_pkg::RAT_W-1:0];
        bvmf_pkg::REG_SHIFT:  cfg.filter_shift     <= pwdata[bvmf_pkg::SHF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      bvmf_pkg::REG_PERIOD: prdata = bvmf_pkg::APB_DW'(cfg.sample_period_ms);
      bvmf_pkg::REG_REF:    prdata = bvmf_pkg::APB_DW'(cfg.reference_mv);
      bvmf_pkg::REG_RATIO:  prdata = bvmf_pkg::APB_DW'(cfg.divider_ratio);
      bvmf_pkg::REG_SHIFT:  prdata = bvmf_pkg::APB_DW'(cfg.filter_shift);
      default:              prdata = '0;
    endcase
  end

  bvmf_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .poll_valid       (poll_valid),
    .poll_stall       (poll_stall),
    .poll             (poll),
    .sample_period_ms (cfg.sample_period_ms),
    .queue_full       (queue_full),
    .push             (push)
  );

  bvmf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  bvmf_back #(
    .ADC_BITS (ADC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> src/bvmf_checker.sv
// ----------------------------------------------------------------------------
// bvmf_checker
// Port-level checks of the bus voltage monitor filter, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bvmf_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input bvmf_pkg::result_t result,
  input logic              pready
);

  `BVMF_ASSERT(a_out_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed or dropped")
  `BVMF_ASSERT(a_taken_loaded, clk, rst, result_valid && result.sample_taken |-> result.reading_valid, "sample taken without a loaded filter")
  `BVMF_ASSERT(a_unloaded_zero, clk, rst, result_valid && !result.reading_valid |-> result.bus_millivolts == '0 && result.last_raw == '0, "unloaded filter shows nonzero data")
  `BVMF_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !result_valid, "result valid right after reset")
  `BVMF_ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")

endmodule

bind bus_voltage_monitor_filter_top bvmf_checker u_bvmf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .pready       (pready)
);

>>> dv/bus_voltage_monitor_filter_checker.sv
// ----------------------------------------------------------------------------
// bus_voltage_monitor_filter_checker
// Watches the poll and result channels and the register port of the bus
// voltage monitor. Keeps its own copy of the sample timer, the scaling and
// the moving-average filter, predicts one reading per poll beat and compares
// each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bus_voltage_monitor_filter_checker
  import bvmf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                poll_valid,
  input  logic                poll_stall,
  input  poll_t               poll,
  input  logic                result_valid,
  input  logic                result_stall,
  input  result_t             result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output int                  mismatch_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ADC_FULL_SCALE = (64'd1 << RAW_W) - 64'd1;
  localparam int              PRINT_CAP      = 200;

  cfg_t              cfg;
  logic [TIME_W-1:0] last_due_ms;
  logic              first_poll;
  logic [RAW_W-1:0]  held_raw;
  logic [MV_W-1:0]   filt_mv;
  logic              filter_loaded;

  result_t expected_readings[$];
  int      errors  = 0;
  int      beat_no = 0;

  assign mismatch_count = errors;

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP)
      $display("[%0t] reading %0d: %s", $time, beat_no, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got)
      report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  // Raw code to millivolts, rounded, saturated to the output width.
  function automatic logic [MV_W-1:0] scale_to_mv(input logic [RAW_W-1:0] raw);
    longint unsigned prod;
    prod = 64'(raw) * 64'(cfg.reference_mv) * 64'(cfg.divider_ratio);
    prod = (prod + ADC_FULL_SCALE / 2) / ADC_FULL_SCALE;
    if (prod > 64'hFFFF)
      prod = 64'hFFFF;
    return MV_W'(prod);
  endfunction

  // Advance the timer and filter by one poll and return the reading it gives.
  function automatic result_t predict_reading(input poll_t p);
    result_t           r;
    logic [TIME_W-1:0] since;
    logic [MV_W-1:0]   fresh;
    int                delta;
    since          = p.now_ms - last_due_ms;
    r.sample_taken = 1'b0;
    if (first_poll || since >= TIME_W'(cfg.sample_period_ms)) begin
      first_poll  = 1'b0;
      last_due_ms = p.now_ms;
      if (p.read_ok) begin
        r.sample_taken = 1'b1;
        held_raw       = p.raw_sample;
        fresh          = scale_to_mv(p.raw_sample);
        if (!filter_loaded) begin
          filt_mv       = fresh;
          filter_loaded = 1'b1;
        end else begin
          // signed step, truncated toward zero
          delta   = (int'(fresh) - int'(filt_mv)) / (1 << cfg.filter_shift);
          filt_mv = MV_W'(int'(filt_mv) + delta);
        end
      end
    end
    r.bus_millivolts = filt_mv;
    r.last_raw       = held_raw;
    r.reading_valid  = filter_loaded;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      expected_readings.delete();
      cfg.sample_period_ms = PERIOD_RST;
      cfg.reference_mv     = REF_RST;
      cfg.divider_ratio    = RATIO_RST;
      cfg.filter_shift     = SHIFT_RST;
      last_due_ms          = '0;
      first_poll           = 1'b1;
      held_raw             = '0;
      filt_mv              = '0;
      filter_loaded        = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_PERIOD: begin
            cfg.sample_period_ms = pwdata[PER_W-1:0];
          end
          REG_REF: begin
            cfg.reference_mv = pwdata[REF_W-1:0];
          end
          REG_RATIO: begin
            cfg.divider_ratio = pwdata[RAT_W-1:0];
          end
          REG_SHIFT: begin
            cfg.filter_shift = pwdata[SHF_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (poll_valid && !poll_stall)
        expected_readings.push_back(predict_reading(poll));

      if (result_valid && !result_stall) begin
        beat_no++;
        if (expected_readings.size() == 0) begin
          report_mismatch("result beat with no reading outstanding");
        end else begin
          want = expected_readings.pop_front();
          check_field("bus_millivolts", want.bus_millivolts, result.bus_millivolts);
          check_field("last_raw", want.last_raw, result.last_raw);
          check_field("reading_valid", want.reading_valid, result.reading_valid);
          check_field("sample_taken", want.sample_taken, result.sample_taken);
        end
      end
    end
    pending <= expected_readings.size();
  end

endmodule

>>> dv/tb_bus_voltage_monitor_filter_top.sv
// ----------------------------------------------------------------------------
// tb_bus_voltage_monitor_filter_top
// Drives polls and register writes into the bus voltage monitor, stalls the
// result channel at random and gives the verdict. A directed pass covers the
// first poll, the period boundary, failed reads, time wrap, saturation, zero
// scale factors and the widest filter shift; random phases with fresh
// register settings follow. Checking lives in the checker instance.
// ----------------------------------------------------------------------------
module tb_bus_voltage_monitor_filter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bvmf_pkg::*;

  localparam int          PHASES       = 8;
  localparam int          PHASE_POLLS  = 240;
  localparam int          DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  logic              clk = 1'b0;
  logic              rst;
  logic              poll_valid;
  logic              poll_stall;
  poll_t             poll;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int          mismatch_count;
  int          pending;
  int          item_no     = 0;
  int          rx_wait     = 0;
  int          rx_beats    = 0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  bus_voltage_monitor_filter_top uut (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll         (poll),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  bus_voltage_monitor_filter_checker reading_chk (
    .clk            (clk),
    .rst            (rst),
    .poll_valid     (poll_valid),
    .poll_stall     (poll_stall),
    .poll           (poll),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("tb_bus_voltage_monitor_filter_top: FAIL");
    $finish;
  end

  // Result side: after each beat raise stall at random; every fourth stretch of 64
  // beats runs without stalls.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      result_stall <= 1'b0;
      rx_wait      <= 0;
    end else if (result_valid && !result_stall) begin
      n = ((rx_beats % 256) >= 192) ? 0 : $urandom_range(0, 7);
      rx_beats     <= rx_beats + 1;
      rx_wait      <= n;
      result_stall <= (n != 0);
    end else if (rx_wait > 0) begin
      rx_wait      <= rx_wait - 1;
      result_stall <= (rx_wait > 1);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Called at a clock edge; leaves valid high so back-to-back beats stay high.
  task automatic send_poll(input poll_t p);
    int gap;
    gap = ((item_no % 160) >= 120) ? 0 : $urandom_range(0, 7);
    item_no++;
    if (gap != 0) begin
      poll_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_valid <= 1'b1;
    poll       <= p;
    do @(posedge clk); while (poll_stall);
  endtask

  task automatic poll_at(input logic [TIME_W-1:0] t, input logic ok,
                         input logic [RAW_W-1:0] raw);
    poll_t p;
    p.now_ms     = t;
    p.read_ok    = ok;
    p.raw_sample = raw;
    send_poll(p);
  endtask

  // Drop valid and wait until every reading has come back.
  task automatic drain();
    poll_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves psel/penable high; the caller drops them after the last write.
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_cfg(input cfg_t c);
    drain();
    write_reg(REG_PERIOD, APB_DW'(c.sample_period_ms));
    write_reg(REG_REF, APB_DW'(c.reference_mv));
    write_reg(REG_RATIO, APB_DW'(c.divider_ratio));
    write_reg(REG_SHIFT, APB_DW'(c.filter_shift));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    case ($urandom_range(0, 4))
      0: c.sample_period_ms = '0;
      1: c.sample_period_ms = PER_W'(1);
      2: c.sample_period_ms = PER_W'($urandom_range(2, 40));
      3: c.sample_period_ms = PER_W'($urandom_range(41, 65534));
      default: c.sample_period_ms = '1;
    endcase
    case ($urandom_range(0, 3))
      0: c.reference_mv = '0;
      1: c.reference_mv = '1;
      default: c.reference_mv = REF_W'($urandom_range(1, 8191));
    endcase
    c.divider_ratio = RAT_W'($urandom_range(0, 15));
    c.filter_shift  = SHF_W'($urandom_range(0, 7));
    return c;
  endfunction

  function automatic logic [RAW_W-1:0] random_raw();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return RAW_W'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    cfg_t              c;
    poll_t             p;
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] span;
    int                kind;

    rst          <= 1'b1;
    poll_valid   <= 1'b0;
    poll         <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first poll due early, boundary, failed read, wrap.
    poll_at(32'd5, 1'b1, 12'd4095);
    poll_at(32'd10, 1'b1, 12'd0);
    poll_at(32'd25, 1'b0, 12'd0);
    poll_at(32'd44, 1'b1, 12'd100);
    poll_at(32'd45, 1'b1, 12'd0);
    poll_at(32'd65, 1'b1, 12'd4095);
    poll_at(32'hFFFF_FFF0, 1'b1, 12'd2048);
    poll_at(32'd4, 1'b1, 12'd1);
    poll_at(32'd5, 1'b1, 12'd4095);

    // Zero period, saturating scale, widest shift.
    apply_cfg('{sample_period_ms: '0, reference_mv: '1, divider_ratio: '1,
                filter_shift: '1});
    poll_at(32'd100, 1'b1, 12'd4095);
    poll_at(32'd100, 1'b1, 12'd0);
    poll_at(32'd100, 1'b0, 12'd4095);
    poll_at(32'd99, 1'b1, 12'd1);
    poll_at(32'd200, 1'b1, 12'd2048);

    // Longest period, zero reference, no filtering.
    apply_cfg('{sample_period_ms: '1, reference_mv: '0, divider_ratio: '1,
                filter_shift: '0});
    poll_at(32'd300, 1'b1, 12'd4095);
    poll_at(32'd200 + 32'd65535, 1'b1, 12'd4095);
    poll_at(32'd200 + 32'd65535 + 32'd65534, 1'b1, 12'd7);

    // Shortest nonzero period, zero ratio.
    apply_cfg('{sample_period_ms: PER_W'(1), reference_mv: REF_W'(5000),
                divider_ratio: '0, filter_shift: SHF_W'(4)});
    poll_at(32'd70000, 1'b1, 12'd3000);
    poll_at(32'd70000, 1'b1, 12'd3000);
    poll_at(32'd70001, 1'b0, 12'd5);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        c = '{sample_period_ms: PERIOD_RST, reference_mv: REF_RST,
              divider_ratio: RATIO_RST, filter_shift: SHIFT_RST};
      else
        c = random_cfg();
      apply_cfg(c);
      // odd phases start just short of the time wrap
      clock_ms = ph[0] ? 32'hFFFF_FF00 + TIME_W'($urandom_range(0, 255)) : $urandom;
      span     = TIME_W'(c.sample_period_ms);
      for (int i = 0; i < PHASE_POLLS; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          // steady polling around the period boundary
          case ($urandom_range(0, 3))
            0: clock_ms = clock_ms + span;
            1: clock_ms = clock_ms + span - 1;
            2: clock_ms = clock_ms + span + 1;
            default: clock_ms = clock_ms + TIME_W'($urandom_range(0, 2 * span + 2));
          endcase
        end else if (kind < 92) begin
          clock_ms = $urandom;
        end else begin
          // time steps back, so elapsed time wraps
          clock_ms = clock_ms - TIME_W'($urandom_range(1, 1000));
        end
        p.now_ms     = clock_ms;
        p.read_ok    = ($urandom_range(0, 9) != 0);
        p.raw_sample = random_raw();
        send_poll(p);
      end
    end

    drain();
    if (mismatch_count == 0)
      $display("tb_bus_voltage_monitor_filter_top: PASS");
    else
      $display("tb_bus_voltage_monitor_filter_top: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/bvmf_pkg.sv
src/bvmf_front.sv
src/bvmf_queue.sv
src/bvmf_back.sv
src/bus_voltage_monitor_filter_top.sv
src/bvmf_checker.sv
dv/bus_voltage_monitor_filter_checker.sv
dv/tb_bus_voltage_monitor_filter_top.sv
